@@ hdl/npm_pkg.sv @@
package npm_pkg;

  localparam int COEF_W     = 16;
  localparam int IDX_W      = 4;
  localparam int OUT_COEF_W = 15;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]      out_index;
    logic [OUT_COEF_W-1:0] out_coef;
    logic                  out_last;
  } out_res_t;

  // Per-cycle commands broadcast to every cell of the row
  typedef struct packed {
    logic load;       // shift operands down, new pair at the top
    logic rot;        // shift a down, rotate b up (multiply by x), form product
    logic acc_clr;    // clear accumulator
    logic acc_add;    // add registered product into accumulator
    logic acc_shift;  // shift accumulators down towards the output
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } npm_state_t;

endpackage

@@ hdl/npm_cell.sv @@
module npm_cell import npm_pkg::*; #(
  parameter int MOD_BITS = 15
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [MOD_BITS-1:0] a_in,
  input  logic [MOD_BITS-1:0] b_load_in,
  input  logic [MOD_BITS-1:0] b_rot_in,
  input  logic [MOD_BITS-1:0] a_bcast,
  input  logic [MOD_BITS-1:0] acc_in,
  output logic [MOD_BITS-1:0] a_out,
  output logic [MOD_BITS-1:0] b_out,
  output logic [MOD_BITS-1:0] acc_out
);

  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic [MOD_BITS-1:0] prod_r;
  logic [MOD_BITS-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.rot) begin
      a_r <= a_in;
    end
    if (ctrl.load) begin
      b_r <= b_load_in;
    end else if (ctrl.rot) begin
      b_r <= b_rot_in;
    end
    // low bits of the product are exact modulo 2^MOD_BITS
    if (ctrl.rot) begin
      prod_r <= MOD_BITS'(a_bcast * b_r);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + prod_r;
    end else if (ctrl.acc_shift) begin
      acc_r <= acc_in;
    end
  end

  assign a_out   = a_r;
  assign b_out   = b_r;
  assign acc_out = acc_r;

endmodule

@@ hdl/npm_ctrl.sv @@
module npm_ctrl import npm_pkg::*; #(
  parameter int DEGREE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cell_ctrl_t       ctrl,
  output logic [IDX_W-1:0] idx,
  output logic             last
);

  localparam int CNT_W = $clog2(DEGREE);

  npm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_end;
  logic             in_acc;
  logic             out_acc;

  assign cnt_end   = (cnt_r == CNT_W'(DEGREE - 1));
  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign last      = cnt_end;

  generate
    if (CNT_W >= IDX_W) begin : g_idx_trunc
      assign idx = cnt_r[IDX_W-1:0];
    end else begin : g_idx_ext
      assign idx = {{(IDX_W-CNT_W){1'b0}}, cnt_r};
    end
  endgenerate

  always_comb begin
    ctrl.load      = in_acc;
    ctrl.rot       = (state_r == ST_MAC);
    ctrl.acc_clr   = in_acc;
    // product is registered, so it trails the rotation
    ctrl.acc_add   = ((state_r == ST_MAC) && (cnt_r != '0)) || (state_r == ST_DRAIN);
    ctrl.acc_shift = out_acc;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_MAC;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_MAC: begin
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (cnt_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/negacyclic_poly_multiplier_core.sv @@
// Channel  Dir  Handshake             Payload
// in_      in   in_valid / in_ready   in_data   : one coefficient pair per request
// out_     out  out_valid / out_ready out_data  : one product coefficient per request
//
// A product passes through a load phase of DEGREE requests, a rotate-and-multiply
// phase, a drain state and an emit phase of DEGREE coefficients, in that order.
// The row of cells owns one multiplier per cell and sees one operand
// coefficient per cycle while multiplying. in_ready is high only while loading.
// Reset (rst_n low, synchronous) returns the sequencer to loading at index zero.
// A stalled out_ready holds the accumulator row and the presented coefficient.
module negacyclic_poly_multiplier_core import npm_pkg::*; #(
  parameter int DEGREE   = 16,
  parameter int MOD_BITS = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  cell_ctrl_t          ctrl;
  logic [IDX_W-1:0]    idx;
  logic                last;
  logic [MOD_BITS-1:0] new_a;
  logic [MOD_BITS-1:0] new_b;

  // Per-cell outputs; cell k holds coefficient k after loading
  logic [MOD_BITS-1:0] a_q   [DEGREE];
  logic [MOD_BITS-1:0] b_q   [DEGREE];
  logic [MOD_BITS-1:0] acc_q [DEGREE];

  npm_ctrl #(
    .DEGREE(DEGREE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctrl     (ctrl),
    .idx      (idx),
    .last     (last)
  );

  // Reduce the signed inputs modulo 2^MOD_BITS: truncate, or sign-extend
  generate
    if (MOD_BITS <= COEF_W) begin : g_in_trunc
      assign new_a = in_data.coef_a[MOD_BITS-1:0];
      assign new_b = in_data.coef_b[MOD_BITS-1:0];
    end else begin : g_in_ext
      assign new_a = {{(MOD_BITS-COEF_W){in_data.coef_a[COEF_W-1]}}, in_data.coef_a};
      assign new_b = {{(MOD_BITS-COEF_W){in_data.coef_b[COEF_W-1]}}, in_data.coef_b};
    end
  endgenerate

  // Row of cells. Loading and accumulator emission shift towards cell 0;
  // b rotates upwards, the coefficient leaving the top re-enters negated
  // at cell 0, which is multiplication by x in the negacyclic ring.
  generate
    for (genvar k = 0; k < DEGREE; k++) begin : g_cell
      logic [MOD_BITS-1:0] a_nb;
      logic [MOD_BITS-1:0] b_load_nb;
      logic [MOD_BITS-1:0] b_rot_nb;
      logic [MOD_BITS-1:0] acc_nb;

      if (k == DEGREE - 1) begin : g_top
        assign a_nb      = new_a;
        assign b_load_nb = new_b;
        assign acc_nb    = '0;
      end else begin : g_mid
        assign a_nb      = a_q[k+1];
        assign b_load_nb = b_q[k+1];
        assign acc_nb    = acc_q[k+1];
      end

      if (k == 0) begin : g_wrap
        assign b_rot_nb = -b_q[DEGREE-1];
      end else begin : g_rot
        assign b_rot_nb = b_q[k-1];
      end

      npm_cell #(
        .MOD_BITS(MOD_BITS)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .a_in     (a_nb),
        .b_load_in(b_load_nb),
        .b_rot_in (b_rot_nb),
        .a_bcast  (a_q[0]),
        .acc_in   (acc_nb),
        .a_out    (a_q[k]),
        .b_out    (b_q[k]),
        .acc_out  (acc_q[k])
      );
    end
  endgenerate

  // Present cell 0's accumulator, fitted to the result field
  generate
    if (MOD_BITS >= OUT_COEF_W) begin : g_out_trunc
      assign out_data.out_coef = acc_q[0][OUT_COEF_W-1:0];
    end else begin : g_out_ext
      assign out_data.out_coef = {{(OUT_COEF_W-MOD_BITS){1'b0}}, acc_q[0]};
    end
  endgenerate

  assign out_data.out_index = idx;
  assign out_data.out_last  = last;

endmodule

@@ test/tb_negacyclic_poly_multiplier_core.sv @@
`timescale 1ns / 1ps

module tb_negacyclic_poly_multiplier_core import npm_pkg::*;;

  localparam int DEGREE    = 16;
  localparam int MOD_BITS  = 15;
  localparam int PRODUCTS  = 10;     // random products after the directed one
  localparam int LONG_HOLD = 300;    // receiver hold-off, in cycles
  localparam int TAIL      = 3 * DEGREE + 16;

  // Predicts every product coefficient from the accepted pairs and checks
  // the emitted coefficients against them in order.
  class poly_product_checker;
    logic signed [COEF_W-1:0] opnd_a[DEGREE];
    logic signed [COEF_W-1:0] opnd_b[DEGREE];
    int unsigned              pairs_loaded;
    out_res_t                 expected_coefs[$];
    int unsigned              pairs_seen;
    int unsigned              products;
    int unsigned              coefs_checked;
    int unsigned              failures;

    // Form the negacyclic product; wrapped terms are subtracted. Only the
    // low MOD_BITS bits of each partial product matter, as q is 2^MOD_BITS.
    function void form_product();
      logic [MOD_BITS-1:0]    terms[DEGREE];
      logic signed [31:0]     prod;
      out_res_t               res;
      for (int k = 0; k < DEGREE; k++) terms[k] = '0;
      for (int i = 0; i < DEGREE; i++) begin
        for (int j = 0; j < DEGREE; j++) begin
          prod = opnd_a[i] * opnd_b[j];
          if (i + j < DEGREE) begin
            terms[i + j] = terms[i + j] + prod[MOD_BITS-1:0];
          end else begin
            terms[i + j - DEGREE] = terms[i + j - DEGREE] - prod[MOD_BITS-1:0];
          end
        end
      end
      for (int k = 0; k < DEGREE; k++) begin
        res.out_index = k[IDX_W-1:0];
        res.out_coef  = terms[k];
        res.out_last  = (k == DEGREE - 1);
        expected_coefs.push_back(res);
      end
      products++;
    endfunction

    function void note_request(in_req_t req);
      opnd_a[pairs_loaded] = req.coef_a;
      opnd_b[pairs_loaded] = req.coef_b;
      pairs_seen++;
      pairs_loaded++;
      if (pairs_loaded == DEGREE) begin
        form_product();
        pairs_loaded = 0;
      end
    endfunction

    function void check_result(out_res_t res);
      out_res_t exp_res;
      if (expected_coefs.size() == 0) begin
        $display("%0t: unexpected coefficient index %0d coef %0d last %0b",
                 $time, res.out_index, res.out_coef, res.out_last);
        failures++;
        return;
      end
      exp_res = expected_coefs.pop_front();
      coefs_checked++;
      if (res.out_index !== exp_res.out_index) begin
        $display("%0t: out_index expected %0d actual %0d",
                 $time, exp_res.out_index, res.out_index);
        failures++;
      end
      if (res.out_coef !== exp_res.out_coef) begin
        $display("%0t: out_coef at index %0d expected %0d actual %0d",
                 $time, exp_res.out_index, exp_res.out_coef, res.out_coef);
        failures++;
      end
      if (res.out_last !== exp_res.out_last) begin
        $display("%0t: out_last at index %0d expected %0b actual %0b",
                 $time, exp_res.out_index, exp_res.out_last, res.out_last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_coefs.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_data;

  poly_product_checker scb = new;

  // Sender pacing: bursts of random length, random gaps between them
  bit          gaps_on;
  int unsigned burst_left;

  // Receiver controls: 0 always ready, 1 random, 2 fixed duty pattern
  int unsigned recv_mode;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned duty_cnt;

  always #5 clk = ~clk;

  negacyclic_poly_multiplier_core #(
    .DEGREE   (DEGREE),
    .MOD_BITS (MOD_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Sample both handshakes at the rising edge, before any register updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) scb.note_request(in_data);
      if (out_valid && out_ready) scb.check_result(out_data);
    end
  end

  // Receiver: count the long hold-off here, otherwise follow the mode.
  always @(negedge clk) begin
    bit rdy;
    if (hold_req && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    duty_cnt = duty_cnt + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rdy = 1'b0;
    end else begin
      case (recv_mode)
        0: begin
          rdy = 1'b1;
        end
        1: begin
          rdy = ($urandom_range(0, 99) < 60);
        end
        default: begin
          rdy = ((duty_cnt % 7) < 4);
        end
      endcase
    end
    out_ready <= rdy;
  end

  // Hold valid low for the idle span n; the next request raises it again.
  task automatic idle_sender(int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    in_data  <= in_req_t'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one pair and hold it until accepted; insert a gap between bursts.
  task automatic send_pair(in_req_t req);
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [COEF_W-1:0] edge_value(int unsigned k);
    case (k % 8)
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd1;
      3: return 16'sd1;
      4: return 16'sd0;
      5: return -16'sd2;
      6: return 16'sd16384;
      default: return -16'sd16384;
    endcase
  endfunction

  // Draw one coefficient in the given style: full range, field extremes,
  // small magnitudes, or mostly zero.
  function automatic logic signed [COEF_W-1:0] draw_coef(int unsigned style);
    case (style)
      0: return COEF_W'($urandom);
      1: return edge_value($urandom_range(0, 7));
      2: return COEF_W'($signed($urandom_range(0, 15)) - 8);
      default: return ($urandom_range(0, 3) == 0) ? COEF_W'($urandom) : 16'sd0;
    endcase
  endfunction

  task automatic send_product(int unsigned style);
    in_req_t req;
    for (int k = 0; k < DEGREE; k++) begin
      req.coef_a = draw_coef(style);
      req.coef_b = draw_coef(style);
      send_pair(req);
    end
  endtask

  task automatic drain_results();
    while (scb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_req_t req;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    recv_mode  = 0;
    hold_req   = 1'b0;
    hold_left  = 0;
    duty_cnt   = 0;
    gaps_on    = 1'b0;
    burst_left = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed product: every extreme against every other, including the
    // most negative value squared and terms that wrap past the top index.
    for (int k = 0; k < DEGREE; k++) begin
      req.coef_a = edge_value(k);
      req.coef_b = edge_value(3 * k + 5);
      send_pair(req);
    end
    idle_sender(1);
    drain_results();

    // Random products with shifting sender and receiver pacing.
    for (int p = 0; p < PRODUCTS; p++) begin
      recv_mode = p % 3;
      gaps_on   = (p % 4 != 0);
      if (p == 4) begin
        // Hold off the receiver and keep offering, so that the block
        // fills up and drops in_ready.
        hold_req = 1'b1;
      end
      if (p == 7) begin
        idle_sender(1);
        drain_results();
      end
      send_product((p < 4) ? 0 : p % 4);
    end
    idle_sender(1);

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (scb.pending() != 0) begin
      $display("%0t: %0d expected coefficients never emitted",
               $time, scb.pending());
      scb.failures++;
    end

    $display("Sent %0d coefficient pairs forming %0d products; checked %0d coefficients,",
             scb.pairs_seen, scb.products, scb.coefs_checked);
    $display("with varied bursts, receiver stalls, a long hold-off and a full drain.");
    if (scb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
